@@ design/shp_pkg.sv @@
// Package for the sponge hash permutation: constants, tables and byte functions.
// Used by the round datapath and the top level.
`timescale 1ns / 1ps
package shp_pkg;

    localparam int StateBytes = 256;
    localparam int Rounds = 24;
    localparam int RoundBits = 5;

    typedef logic [StateBytes*8-1:0] state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_ROUND,
        ST_EMIT
    } ctrl_state_t;

    localparam logic [7:0] XtimePoly = 8'h1b;

    localparam logic [511:0] RcInit = {
        64'h243f6a8885a308d3, 64'h13198a2e03707344,
        64'ha4093822299f31d0, 64'h082efa98ec4e6c89,
        64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'hc0ac29b7c97c50dd, 64'h3f84d5b5b5470917
    };

    localparam state_t IvInit = {
        128'hda67341bc43d1f97c385e99bae65d59e, 128'hcf1d960ddae77906a6f4f96b4a8d26c3,
        128'hf6f3a1b21344279d68f1a22f031e7702, 128'he503ea25cbf5de3045b447ac973299c4,
        128'h15b574d6cbc33ac2a9b87cc493982423, 128'h723b518e2f48478ce904fc5c908e99d8,
        128'h20e4c645662371789d26650d2e8cf4cc, 128'h7bb83765ec06e09cee897edb581804d3,
        128'hf56cefad4827374ae8b8365c0c874289, 128'h0a131c0f8b60a42742f9810ac9a00813,
        128'hdb3122544422ca4b6d1376c3c45080bd, 128'h43445c2312d1584c228b8b11d4bc6d2f,
        128'hefb96f8bfb01cb43de71b14d2bbe4332, 128'h9306ef5f4b77a9c1f5ecfff16852d7ee,
        128'hab6ff3fe5c5b1080fe597713aa717cf5, 128'hd3a033228de22e6ba05ec0a10db1abf0
    };

    function automatic logic [3:0] sbox4(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'd9;   4'h1: y = 4'd0;   4'h2: y = 4'd4;   4'h3: y = 4'd11;
            4'h4: y = 4'd13;  4'h5: y = 4'd12;  4'h6: y = 4'd3;   4'h7: y = 4'd15;
            4'h8: y = 4'd1;   4'h9: y = 4'd10;  4'ha: y = 4'd2;   4'hb: y = 4'd6;
            4'hc: y = 4'd7;   4'hd: y = 4'd5;   4'he: y = 4'd8;   default: y = 4'd14;
        endcase
        return y;
    endfunction

    function automatic logic [7:0] sbox8(input logic [7:0] x);
        logic [3:0] r1;
        logic [3:0] r2;
        logic [3:0] r3;
        r1 = x[7:4] ^ sbox4(x[3:0]);
        r2 = x[3:0] ^ sbox4(r1);
        r3 = r1 ^ sbox4(r2);
        return {r2, r3};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? XtimePoly : 8'h00);
    endfunction

    function automatic logic [63:0] rc_step(input logic [63:0] c);
        return {c[60:0], c[63:61]} ^ {c[56:0], c[63:57]} ^ {c[51:0], c[63:52]};
    endfunction

endpackage

@@ design/shp_round.sv @@
// One permutation round datapath: constant injection, S-box, mixing, shuffle.
// Depends on shp_pkg.
`timescale 1ns / 1ps
module shp_round
    import shp_pkg::*;
(
    input  state_t         state_in,
    input  logic [511:0]   rc,
    input  logic           add_rc,
    input  logic [1:0]     mode,
    output state_t         state_out
);

    logic [7:0] b [StateBytes];
    logic [7:0] s [StateBytes];
    logic [7:0] m [StateBytes];
    logic [7:0] t [StateBytes];

    // constant injection and S-box, byte 0 at the top of the vector
    always_comb
    begin
        for (int i = 0; i < StateBytes; i++)
        begin
            b[i] = state_in[(StateBytes-1-i)*8 +: 8];
            if (add_rc && i < 64)
                b[i] = b[i] ^ rc[(63-i)*8 +: 8];
            s[i] = sbox8(b[i]);
        end
    end

    // four-row mix within each half
    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            for (int j = 0; j < 32; j++)
            begin
                logic [7:0] a0, a1, a2, a3, x;
                a0 = s[128*h + j];
                a1 = s[128*h + j + 32];
                a2 = s[128*h + j + 64];
                a3 = s[128*h + j + 96];
                x = a0 ^ a1 ^ a2 ^ a3;
                m[128*h + j]      = a0 ^ x ^ xtime(a0 ^ a1);
                m[128*h + j + 32] = a1 ^ x ^ xtime(a1 ^ a2);
                m[128*h + j + 64] = a2 ^ x ^ xtime(a2 ^ a3);
                m[128*h + j + 96] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
    end

    // byte shuffle chosen by round mod 3
    always_comb
    begin
        for (int i = 0; i < StateBytes; i++)
        begin
            int r;
            int p;
            int q;
            r = (i >> 5) & 3;
            p = (i >> 5) & 7;
            p = (p < 4) ? p : p - 4;
            q = ((i >> 5) < 4) ? ((i >> 4) & 1) : (((i >> 4) & 1) + 2);
            case (mode)
                2'd0: t[i] = m[(i & ~3) | ((i + r) & 3)];
                2'd1: t[i] = m[(i & ~15) | ((i + 4*r) & 15)];
                default:
                begin
                    int qq;
                    qq = (q + p) & 3;
                    t[i] = m[((qq < 2) ? (32*p + 16*qq) : (32*(p+4) + 16*(qq-2)))
                             + (i & 15)];
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < StateBytes; i++)
            state_out[(StateBytes-1-i)*8 +: 8] = t[i];
    end

endmodule

@@ design/sponge_hash_2048_permutation.sv @@
// Top level: word buffer, sequencer and the shared round unit.
// A word that fills no block is only stored in the buffer; a full block adds an absorb step and 24 rounds,
// one round per cycle through one shared round unit. In_stall stays high until the rounds end,
// so no new word is taken while a block is absorbed and permuted.
// On last, up to two absorbs then eight digest items, one a cycle while out_stall is low.
// Reset (rst_n, asynchronous) loads the initial state and clears buffer and length.
`timescale 1ns / 1ps
module sponge_hash_2048_permutation
    import shp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [6:0]  word_bits,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic        last_word
);

    ctrl_state_t state_reg, state_next;
    state_t chain_reg, chain_next;
    logic [1023:0] buf_reg, buf_next;
    logic [3:0] idx_reg, idx_next;
    logic [63:0] len_reg, len_next;
    logic [511:0] rc_reg, rc_next;
    logic [RoundBits-1:0] rnd_reg, rnd_next;
    logic [1:0] mode_reg, mode_next;
    logic fin_reg, fin_next;     // final sequence in progress
    logic lenblk_reg, lenblk_next; // current absorb is the length block
    logic [2:0] out_cnt_reg, out_cnt_next;
    state_t round_out;
    logic accept;
    logic [6:0] bits;
    logic [63:0] masked;

    shp_round u_round (
        .state_in  (chain_reg),
        .rc        (rc_reg),
        .add_rc    (rnd_reg[1:0] == 2'd0),
        .mode      (mode_reg),
        .state_out (round_out)
    );

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[2047 - 64*out_cnt_reg -: 64];
    assign last_word = (out_cnt_reg == 3'd7);
    assign bits = word_bits[6] ? 7'd64 : word_bits;
    assign masked = data_word & ~(64'hffff_ffff_ffff_ffff >> bits);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && ((bits != 7'd0 && idx_reg == 4'd15) || last))
                    state_next = ST_ABSORB;
            ST_ABSORB: state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == RoundBits'(Rounds - 1))
                    state_next = !fin_reg ? ST_IDLE : (lenblk_reg ? ST_EMIT : ST_ABSORB);
            ST_EMIT:
                if (!out_stall && out_cnt_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        chain_next = chain_reg;
        buf_next = buf_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        rc_next = rc_reg;
        rnd_next = rnd_reg;
        mode_next = mode_reg;
        fin_next = fin_reg;
        lenblk_next = lenblk_reg;
        out_cnt_next = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    fin_next = last;
                    lenblk_next = 1'b0;
                    if (bits != 7'd0)
                    begin
                        buf_next[1023 - 64*idx_reg -: 64] = masked;
                        len_next = len_reg + 64'(bits);
                        idx_next = idx_reg + 4'd1;
                    end
                    // nothing pending at end of message: go straight to length block
                    if (last && (bits == 7'd0 ? idx_reg == 4'd0 : idx_reg == 4'd15)
                        && !(bits != 7'd0))
                    begin
                        buf_next = '0;
                        buf_next[63:0] = len_reg;
                        lenblk_next = 1'b1;
                    end
                end
            ST_ABSORB:
            begin
                chain_next[2047 -: 512] = chain_reg[2047 -: 512] ^ buf_reg[1023 -: 512];
                chain_next[1023 -: 512] = chain_reg[1023 -: 512] ^ buf_reg[511:0];
                rc_next = RcInit;
                rnd_next = '0;
                mode_next = 2'd0;
            end
            ST_ROUND:
            begin
                chain_next = round_out;
                rnd_next = rnd_reg + 1'b1;
                mode_next = (mode_reg == 2'd2) ? 2'd0 : mode_reg + 2'd1;
                if (rnd_reg[1:0] == 2'd3)
                    for (int i = 0; i < 8; i++)
                        rc_next[511 - 64*i -: 64] = rc_step(rc_reg[511 - 64*i -: 64]);
                if (rnd_reg == RoundBits'(Rounds - 1))
                begin
                    idx_next = 4'd0;
                    buf_next = '0;
                    if (fin_reg && !lenblk_reg)
                    begin
                        buf_next[63:0] = len_reg;
                        lenblk_next = 1'b1;
                    end
                    out_cnt_next = 3'd0;
                end
            end
            ST_EMIT:
                if (!out_stall)
                begin
                    out_cnt_next = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == 3'd7)
                    begin
                        chain_next = IvInit;
                        len_next = '0;
                        fin_next = 1'b0;
                        lenblk_next = 1'b0;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= IvInit;
            buf_reg <= '0;
            idx_reg <= '0;
            len_reg <= '0;
            rc_reg <= RcInit;
            rnd_reg <= '0;
            mode_reg <= '0;
            fin_reg <= 1'b0;
            lenblk_reg <= 1'b0;
            out_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            buf_reg <= buf_next;
            idx_reg <= idx_next;
            len_reg <= len_next;
            rc_reg <= rc_next;
            rnd_reg <= rnd_next;
            mode_reg <= mode_next;
            fin_reg <= fin_next;
            lenblk_reg <= lenblk_next;
            out_cnt_reg <= out_cnt_next;
        end
    end

endmodule

@@ design/shp_checker.sv @@
// Port-level checker for the sponge hash block, bound to the top level.
// Depends on nothing but the top-level ports.
`timescale 1ns / 1ps
module shp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] digest_word,
    input logic        last_word
);

    // no new item is taken while digest items are offered
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken during digest");

    // a stalled digest item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(last_word))
        else $error("stalled digest item changed");

    // after the final digest item the block is ready again
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_word |=> !out_valid && !in_stall)
        else $error("not idle after digest");

endmodule

bind sponge_hash_2048_permutation shp_checker u_shp_checker (.*);
